// ===== rtl/core/utf8_validating_prefix_copy_top_defines.svh =====
// Assertion helpers shared by the validating copier RTL.
`ifndef UTF8_VALIDATING_PREFIX_COPY_TOP_DEFINES_SVH
`define UTF8_VALIDATING_PREFIX_COPY_TOP_DEFINES_SVH

// Checked on every edge outside reset.
`define UTFV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define UTFV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/utfv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// utfv_pkg
// Shared types and constants of the UTF-8 validating prefix copier.
// ---------------------------------------------------------------------------
package utfv_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_INPUT_LIMIT = 2'd0;
    localparam logic [1:0] CFG_OUTPUT_CAP  = 2'd1;

    // Result kinds
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Lead byte ranges and continuation marks
    localparam logic [7:0] LEAD2_LO   = 8'hC2;
    localparam logic [7:0] LEAD2_HI   = 8'hDF;
    localparam logic [7:0] LEAD3_LO   = 8'hE0;
    localparam logic [7:0] LEAD3_HI   = 8'hEF;
    localparam logic [7:0] LEAD4_LO   = 8'hF0;
    localparam logic [7:0] LEAD4_HI   = 8'hF4;
    localparam logic [7:0] ASCII_END  = 8'h80;
    localparam logic [1:0] CONT_TAG   = 2'b10;

    // Code point limits
    localparam logic [20:0] CP_MIN3      = 21'h000800;
    localparam logic [20:0] CP_MIN4      = 21'h010000;
    localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    // One queued run: up to four bytes or one finish
    typedef struct packed {
        logic            fin;
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
        logic [15:0]     length;
    } t_cmd;

endpackage
`default_nettype wire

// ===== rtl/core/utfv_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// utfv_front
// Accepts text beats, decodes and validates UTF-8 sequences, queues runs.
// ---------------------------------------------------------------------------
`include "utf8_validating_prefix_copy_top_defines.svh"
module utfv_front #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_end_of_text,
    input  wire logic [15:0]   i_cfg_limit,
    input  wire logic [15:0]   i_cfg_cap,
    output logic               o_push,
    output utfv_pkg::t_cmd     o_cmd,
    input  wire logic          i_q_ready
);
    import utfv_pkg::*;

    localparam int CW = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;

    logic [2:0][7:0]        r_held, n_held;
    logic [1:0]             r_held_cnt, n_held_cnt;
    logic [2:0]             r_exp_len, n_exp_len;
    logic [20:0]            r_cp, n_cp;
    // consumed and emitted counts always move together: one counter
    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic                   r_stopped, n_stopped;

    logic                   w_lead_ok;
    logic [2:0]             w_lead_len;
    logic [20:0]            w_lead_cp;
    logic [2:0]             w_len;
    logic [CW-1:0]          w_sum;
    logic                   w_fits;
    logic [20:0]            w_cp_next;
    logic                   w_cp_bad;
    logic [31:0]            w_len32;

    assign o_ready = i_q_ready;

    always_comb begin
        w_lead_ok  = 1'b1;
        w_lead_len = 3'd1;
        w_lead_cp  = '0;
        if (i_data_byte < ASCII_END) begin
            w_lead_len = 3'd1;
        end else if (i_data_byte >= LEAD2_LO && i_data_byte <= LEAD2_HI) begin
            w_lead_len = 3'd2;
            w_lead_cp  = {16'd0, i_data_byte[4:0]};
        end else if (i_data_byte >= LEAD3_LO && i_data_byte <= LEAD3_HI) begin
            w_lead_len = 3'd3;
            w_lead_cp  = {17'd0, i_data_byte[3:0]};
        end else if (i_data_byte >= LEAD4_LO && i_data_byte <= LEAD4_HI) begin
            w_lead_len = 3'd4;
            w_lead_cp  = {18'd0, i_data_byte[2:0]};
        end else begin
            w_lead_ok  = 1'b0;
        end
    end

    // room check: limit, capacity minus terminator, counter range
    always_comb begin
        w_len  = (r_held_cnt == 2'd0) ? w_lead_len : r_exp_len;
        w_sum  = CW'(r_count) + CW'(w_len);
        w_fits = (w_sum <= CW'(i_cfg_limit)) && (w_sum < CW'(i_cfg_cap)) &&
                 (w_sum[CW-1:LENGTH_BITS] == '0);
    end

    always_comb begin
        w_cp_next = {r_cp[14:0], i_data_byte[5:0]};
        w_cp_bad  = (r_exp_len == 3'd3 && w_cp_next < CP_MIN3) ||
                    (r_exp_len == 3'd4 && w_cp_next < CP_MIN4) ||
                    (w_cp_next >= CP_SURR_LO && w_cp_next <= CP_SURR_HI) ||
                    (w_cp_next > CP_MAX);
        w_len32   = 32'(r_count);
    end

    always_comb begin
        n_held     = r_held;
        n_held_cnt = r_held_cnt;
        n_exp_len  = r_exp_len;
        n_cp       = r_cp;
        n_count    = r_count;
        n_stopped  = r_stopped;
        o_push     = 1'b0;
        o_cmd      = '0;
        if (i_valid && o_ready) begin
            if (i_end_of_text) begin
                o_push       = 1'b1;
                o_cmd.fin    = KIND_FINISH;
                o_cmd.length = w_len32[15:0];
                n_held_cnt   = '0;
                n_exp_len    = '0;
                n_cp         = '0;
                n_count      = '0;
                n_stopped    = 1'b0;
            end else if (!r_stopped) begin
                if (r_held_cnt == 2'd0) begin
                    if (!w_lead_ok || !w_fits) begin
                        n_stopped = 1'b1;
                    end else if (w_lead_len == 3'd1) begin
                        o_push         = 1'b1;
                        o_cmd.bytes[0] = i_data_byte;
                        n_count        = w_sum[LENGTH_BITS-1:0];
                    end else begin
                        n_held[0]  = i_data_byte;
                        n_held_cnt = 2'd1;
                        n_exp_len  = w_lead_len;
                        n_cp       = w_lead_cp;
                    end
                end else if (i_data_byte[7:6] != CONT_TAG) begin
                    n_stopped  = 1'b1;
                    n_held_cnt = '0;
                    n_exp_len  = '0;
                    n_cp       = '0;
                end else if ((3'(r_held_cnt) + 3'd1) < r_exp_len) begin
                    n_held[r_held_cnt] = i_data_byte;
                    n_held_cnt         = r_held_cnt + 2'd1;
                    n_cp               = w_cp_next;
                end else begin
                    n_held_cnt = '0;
                    n_exp_len  = '0;
                    n_cp       = '0;
                    if (w_cp_bad || !w_fits) begin
                        n_stopped = 1'b1;
                    end else begin
                        o_push         = 1'b1;
                        o_cmd.last_idx = r_held_cnt;
                        o_cmd.bytes[0] = r_held[0];
                        o_cmd.bytes[1] = (r_held_cnt > 2'd1) ? r_held[1] : i_data_byte;
                        o_cmd.bytes[2] = (r_held_cnt > 2'd2) ? r_held[2] : i_data_byte;
                        o_cmd.bytes[3] = i_data_byte;
                        n_count        = w_sum[LENGTH_BITS-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        if (!i_rst_n) begin
            r_held_cnt <= '0;
            r_exp_len  <= '0;
            r_cp       <= '0;
            r_count    <= '0;
            r_stopped  <= 1'b0;
        end else begin
            r_held_cnt <= n_held_cnt;
            r_exp_len  <= n_exp_len;
            r_cp       <= n_cp;
            r_count    <= n_count;
            r_stopped  <= n_stopped;
        end
    end

    `UTFV_ASSERT(a_held_not_stopped, (r_held_cnt != 2'd0) |-> !r_stopped, "held bytes while stopped")
    `UTFV_ASSERT(a_held_below_len, (r_held_cnt != 2'd0) |-> (3'(r_held_cnt) < r_exp_len), "held count reached sequence length")

endmodule
`default_nettype wire

// ===== rtl/core/utfv_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// utfv_queue
// Short FIFO of decoded runs between the front and back.
// ---------------------------------------------------------------------------
`include "utf8_validating_prefix_copy_top_defines.svh"
module utfv_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  utfv_pkg::t_cmd     i_cmd,
    output logic               o_ready,
    output logic               o_valid,
    output utfv_pkg::t_cmd     o_cmd,
    input  wire logic          i_pop
);
    import utfv_pkg::*;

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0] r_cnt, n_cnt;
    logic                 w_do_push;
    logic                 w_do_pop;

    assign o_ready = (r_cnt != QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        w_do_push = i_push && o_ready;
        w_do_pop  = i_pop && o_valid;
        n_wr_ptr  = w_do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr  = w_do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt     = r_cnt + QCNT_BITS'(w_do_push) - QCNT_BITS'(w_do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    `UTFV_ASSERT(a_cnt_in_range, r_cnt <= QCNT_BITS'(QUEUE_DEPTH), "queue count overflow")
    `UTFV_ASSERT(a_ptr_gap, (r_cnt != QCNT_BITS'(QUEUE_DEPTH) && r_cnt != '0) |-> (r_wr_ptr != r_rd_ptr), "pointers disagree with count")

endmodule
`default_nettype wire

// ===== rtl/core/utfv_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// utfv_back
// Unrolls queued runs into result beats through an output register.
// ---------------------------------------------------------------------------
module utfv_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  utfv_pkg::t_cmd     i_q_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic               o_result_kind,
    output logic [7:0]         o_copied_byte,
    output logic [15:0]        o_copied_length,
    output logic               o_last_of_run
);
    import utfv_pkg::*;

    logic [1:0]  r_idx, n_idx;
    logic        r_valid, n_valid;
    logic        r_kind, n_kind;
    logic [7:0]  r_byte, n_byte;
    logic [15:0] r_length, n_length;
    logic        r_last, n_last;
    logic        w_load;
    logic        w_is_last;

    always_comb begin
        w_load    = i_q_valid && (!r_valid || i_ready);
        w_is_last = i_q_cmd.fin || (r_idx == i_q_cmd.last_idx);
        o_pop     = w_load && w_is_last;
        n_idx     = r_idx;
        n_valid   = r_valid && !i_ready;
        n_kind    = r_kind;
        n_byte    = r_byte;
        n_length  = r_length;
        n_last    = r_last;
        if (w_load) begin
            n_valid  = 1'b1;
            n_kind   = i_q_cmd.fin;
            n_byte   = i_q_cmd.fin ? 8'd0 : i_q_cmd.bytes[r_idx];
            n_length = i_q_cmd.fin ? i_q_cmd.length : 16'd0;
            n_last   = w_is_last;
            n_idx    = w_is_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_byte   <= n_byte;
        r_length <= n_length;
        r_last   <= n_last;
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    assign o_valid         = r_valid;
    assign o_result_kind   = r_kind;
    assign o_copied_byte   = r_byte;
    assign o_copied_length = r_length;
    assign o_last_of_run   = r_last;

endmodule
`default_nettype wire

// ===== rtl/core/utf8_validating_prefix_copy_top.sv =====
// Path: an accepted input beat is written into the run queue, then loaded into the back's
// output register, which drives o_valid and the result fields.
// Throughput: one input and, with i_ready high, one result beat per cycle; o_ready drops only
// while the four-entry run queue is full, and a run of up to four beats drains at one per cycle.
// Reset (synchronous, active low): clears per-string state, empties the queue,
// and sets the byte limit to 65535 and the capacity to 256.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// utf8_validating_prefix_copy_top
// UTF-8 validating prefix copier: decode front, run queue, result back.
// ---------------------------------------------------------------------------
module utf8_validating_prefix_copy_top #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_text,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_result_kind,
    output logic [7:0]       o_copied_byte,
    output logic [15:0]      o_copied_length,
    output logic             o_last_of_run,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import utfv_pkg::*;

    logic [15:0] r_cfg_limit;
    logic [15:0] r_cfg_cap;
    logic        w_push;
    t_cmd        w_push_cmd;
    logic        w_q_ready;
    logic        w_q_valid;
    t_cmd        w_q_cmd;
    logic        w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_limit <= 16'hFFFF;
            r_cfg_cap   <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INPUT_LIMIT: r_cfg_limit <= i_cfg_data;
                CFG_OUTPUT_CAP:  r_cfg_cap   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    utfv_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .i_cfg_limit   (r_cfg_limit),
        .i_cfg_cap     (r_cfg_cap),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd),
        .i_q_ready     (w_q_ready)
    );

    utfv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    utfv_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_cmd         (w_q_cmd),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result_kind   (o_result_kind),
        .o_copied_byte   (o_copied_byte),
        .o_copied_length (o_copied_length),
        .o_last_of_run   (o_last_of_run)
    );

endmodule
`default_nettype wire
